// ===== rtl/core/cdrc_pkg.sv =====
// Package for the cartridge DMA register controller.
// Holds the word types, register numbers, target codes and default sizes.
// No dependencies; every module of the block imports it.
package cdrc_pkg;

    // Default sizes.
    localparam int SAVE_RAM_BYTES_DEF = 32768;
    localparam int NUM_REGS_DEF       = 13;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int ROM_W    = 26;
    localparam int DRAM_W   = 23;
    localparam int OFFSET_W = 25;
    localparam int LENGTH_W = 25;
    localparam int LENFLD_W = 24;
    localparam int CART_W   = 28;
    localparam int SRAM_OFF_W = 15;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register numbers.
    localparam logic [INDEX_W-1:0] REG_DRAM   = 4'd0;
    localparam logic [INDEX_W-1:0] REG_CART   = 4'd1;
    localparam logic [INDEX_W-1:0] REG_RDLEN  = 4'd2;
    localparam logic [INDEX_W-1:0] REG_WRLEN  = 4'd3;
    localparam logic [INDEX_W-1:0] REG_STATUS = 4'd4;

    // Cart address decode bits.
    localparam int CART_SRAM_BIT = 27;

    // Status bits.
    localparam int ST_RESET_BIT = 0;
    localparam int ST_CLRIRQ_BIT = 1;
    localparam int ST_DONE_BIT  = 3;

    // Device-side targets.
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_SRAM = 2'd1;
    localparam logic [1:0] TGT_ROM  = 2'd2;

    // One bus access.
    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] reg_index;
        logic [DATA_W-1:0]  write_data;
    } t_cdrc_in;

    // One result word.
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                irq_pending;
        logic                dma_start;
        logic                dma_to_dram;
        logic [1:0]          dma_target;
        logic [DRAM_W-1:0]   dram_address;
        logic [OFFSET_W-1:0] device_offset;
        logic [LENGTH_W-1:0] dma_length;
    } t_cdrc_out;

    // Transfer descriptor plus the amount the address registers advance.
    typedef struct packed {
        logic                valid;
        logic [1:0]          target;
        logic [DRAM_W-1:0]   dram_address;
        logic [OFFSET_W-1:0] device_offset;
        logic [LENGTH_W-1:0] length;
        logic [LENGTH_W-1:0] advance;
    } t_cdrc_xfer;

endpackage

// ===== rtl/core/cdrc_xfer.sv =====
// Transfer setup: target decode, length rounding and trimming.
// Pure combinational logic; depends on cdrc_pkg.
module cdrc_xfer #(
    parameter int SAVE_RAM_BYTES = cdrc_pkg::SAVE_RAM_BYTES_DEF
) (
    input  logic [cdrc_pkg::LENFLD_W-1:0] i_len_field,
    input  logic [cdrc_pkg::DATA_W-1:0]   i_cart_reg,
    input  logic [cdrc_pkg::DATA_W-1:0]   i_dram_reg,
    input  logic                          i_to_dram,
    input  logic [cdrc_pkg::ROM_W-1:0]    i_rom_bytes,
    output cdrc_pkg::t_cdrc_xfer          o_xfer
);
    import cdrc_pkg::*;

    localparam logic [ROM_W-1:0] SAVE_END = ROM_W'(SAVE_RAM_BYTES);

    logic [CART_W-1:0]   cart;
    logic [LENGTH_W-1:0] rounded;
    logic [1:0]          target;
    logic [ROM_W-1:0]    off;
    logic [ROM_W-1:0]    lim;
    logic [ROM_W-1:0]    room;
    logic [ROM_W-1:0]    trimmed;

    assign cart = i_cart_reg[CART_W-1:0];

    // Field plus one rounded up to a multiple of 8 equals (field/8 + 1) * 8.
    assign rounded = {(LENGTH_W-3)'({1'b0, i_len_field[LENFLD_W-1:3]}) + 1'b1, 3'b000};

    // Pick the target and its window from the cart address.
    always_comb begin
        target = TGT_NONE;
        off    = '0;
        lim    = '0;
        if (cart[CART_SRAM_BIT]) begin
            target = TGT_SRAM;
            off    = ROM_W'(cart[SRAM_OFF_W-1:0]);
            lim    = SAVE_END;
        end else if (cart[CART_SRAM_BIT-1:CART_SRAM_BIT-2] == 2'b00 && i_to_dram) begin
            target = TGT_ROM;
            off    = ROM_W'(cart[OFFSET_W-1:0]);
            lim    = i_rom_bytes;
        end
    end

    // Trim the length to the end of the window.
    assign room = lim - off;
    always_comb begin
        if (off >= lim) begin
            trimmed = '0;
        end else if (ROM_W'(rounded) > room) begin
            trimmed = room;
        end else begin
            trimmed = ROM_W'(rounded);
        end
    end

    // Descriptor; all zero but the advance, which keeps the rounded length, when there is no target.
    always_comb begin
        o_xfer = '0;
        if (target != TGT_NONE) begin
            o_xfer.valid         = 1'b1;
            o_xfer.target        = target;
            o_xfer.dram_address  = i_dram_reg[DRAM_W-1:0];
            o_xfer.device_offset = off[OFFSET_W-1:0];
            o_xfer.length        = trimmed[LENGTH_W-1:0];
            o_xfer.advance       = trimmed[LENGTH_W-1:0];
        end else begin
            o_xfer.advance       = rounded;
        end
    end

endmodule

// ===== rtl/core/cdrc_regfile.sv =====
// Register file, interrupt flag and per-access result logic.
// Depends on cdrc_pkg and cdrc_xfer.
module cdrc_regfile #(
    parameter int SAVE_RAM_BYTES = cdrc_pkg::SAVE_RAM_BYTES_DEF,
    parameter int NUM_REGS       = cdrc_pkg::NUM_REGS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  cdrc_pkg::t_cdrc_in         i_item,
    input  logic [cdrc_pkg::ROM_W-1:0] i_rom_bytes,
    output cdrc_pkg::t_cdrc_out        o_result
);
    import cdrc_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [DATA_W-1:0] r_regs [NUM_REGS];
    logic [DATA_W-1:0] n_regs [NUM_REGS];
    logic              r_irq;
    logic              n_irq;

    logic              in_range;
    logic [IDX_W-1:0]  ix;
    logic              len_write;
    t_cdrc_xfer        xfer;
    logic [DATA_W-1:0] wdata;

    assign wdata     = i_item.write_data;
    assign in_range  = (5'(i_item.reg_index) < 5'(NUM_REGS));
    assign ix        = i_item.reg_index[IDX_W-1:0];
    assign len_write = in_range && (i_item.kind == KIND_WRITE) &&
                       (i_item.reg_index == REG_RDLEN || i_item.reg_index == REG_WRLEN);

    // Transfer setup uses the freshly written length field.
    cdrc_xfer #(
        .SAVE_RAM_BYTES(SAVE_RAM_BYTES)
    ) u_xfer (
        .i_len_field (wdata[LENFLD_W-1:0]),
        .i_cart_reg  (r_regs[REG_CART[IDX_W-1:0]]),
        .i_dram_reg  (r_regs[REG_DRAM[IDX_W-1:0]]),
        .i_to_dram   (i_item.reg_index == REG_WRLEN),
        .i_rom_bytes (i_rom_bytes),
        .o_xfer      (xfer)
    );

    // Next state and result for the access in the input register.
    always_comb begin
        n_regs   = r_regs;
        n_irq    = r_irq;
        o_result = '0;
        if (in_range) begin
            if (i_item.kind == KIND_READ) begin
                o_result.read_data = r_regs[ix];
            end else begin
                n_regs[ix] = wdata;
                unique case (i_item.reg_index)
                    REG_RDLEN, REG_WRLEN: begin
                        n_regs[REG_DRAM[IDX_W-1:0]] =
                            r_regs[REG_DRAM[IDX_W-1:0]] + DATA_W'(xfer.advance);
                        n_regs[REG_CART[IDX_W-1:0]] =
                            r_regs[REG_CART[IDX_W-1:0]] + DATA_W'(xfer.advance);
                        n_regs[REG_STATUS[IDX_W-1:0]] = r_regs[REG_STATUS[IDX_W-1:0]];
                        n_regs[REG_STATUS[IDX_W-1:0]][ST_RESET_BIT] = 1'b0;
                        n_regs[REG_STATUS[IDX_W-1:0]][ST_DONE_BIT]  = 1'b1;
                        n_irq = 1'b1;
                    end
                    REG_STATUS: begin
                        if (wdata[ST_RESET_BIT]) begin
                            n_regs[REG_STATUS[IDX_W-1:0]] = '0;
                        end
                        if (wdata[ST_CLRIRQ_BIT]) begin
                            n_regs[REG_STATUS[IDX_W-1:0]][ST_DONE_BIT] = 1'b0;
                            n_irq = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (len_write && xfer.valid) begin
            o_result.dma_start     = 1'b1;
            o_result.dma_to_dram   = (i_item.reg_index == REG_WRLEN);
            o_result.dma_target    = xfer.target;
            o_result.dram_address  = xfer.dram_address;
            o_result.device_offset = xfer.device_offset;
            o_result.dma_length    = xfer.length;
        end
        o_result.irq_pending = n_irq;
    end

    // State update, once per access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_irq <= 1'b0;
        end else if (i_go) begin
            r_regs <= n_regs;
            r_irq  <= n_irq;
        end
    end

    // A length write always leaves the interrupt raised.
    a_len_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && len_write) |=> r_irq)
        else $error("interrupt not raised after a transfer request");

    // A transfer is only issued by a length write and always has a target.
    a_start_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.dma_start |-> (len_write && o_result.dma_target != TGT_NONE))
        else $error("transfer issued without a length write or target");

    // Cartridge ROM is never written.
    a_rom_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.dma_target == TGT_ROM) |-> o_result.dma_to_dram)
        else $error("transfer toward cartridge ROM");

    // Register state only moves when an access is processed.
    a_irq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_go |=> $stable(r_irq))
        else $error("interrupt flag changed without an access");

endmodule

// ===== rtl/core/cart_dma_register_controller_core.sv =====
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while the result is not stalled; the register file read-modify-write is combinational.
// The input register is released whenever the result register is empty or being taken.
// Reset: synchronous, active low; clears the register file, interrupt and ROM size to zero.
// Top level of the cartridge DMA register controller.
// Depends on cdrc_pkg and cdrc_regfile.
module cart_dma_register_controller_core #(
    parameter int SAVE_RAM_BYTES = cdrc_pkg::SAVE_RAM_BYTES_DEF,
    parameter int NUM_REGS       = cdrc_pkg::NUM_REGS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cdrc_pkg::t_cdrc_in         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cdrc_pkg::t_cdrc_out        o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cdrc_pkg::ROM_W-1:0] i_cfg_data
);
    import cdrc_pkg::*;

    logic             r_in_valid;
    t_cdrc_in         r_in;
    logic             r_out_valid;
    t_cdrc_out        r_out;
    logic [ROM_W-1:0] r_rom_bytes;

    logic      go;
    logic      in_take;
    t_cdrc_out result;

    // The access in the input register moves on when the result slot frees up.
    assign go          = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !go;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    cdrc_regfile #(
        .SAVE_RAM_BYTES(SAVE_RAM_BYTES),
        .NUM_REGS      (NUM_REGS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (r_in),
        .i_rom_bytes (r_rom_bytes),
        .o_result    (result)
    );

    // Input, result and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rom_bytes <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_rom_bytes <= i_cfg_data;
            end
        end
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (go) begin
            r_out <= result;
        end
    end

    // A processed access always lands in the result register.
    a_go_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> r_out_valid)
        else $error("processed access lost");

    // Backpressure only with a held access and a blocked result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

    // A held result is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !go)
        else $error("result overwritten while stalled");

endmodule
